// ===== design/ktlc_pkg.sv =====
// Package for the key telephone line controller: word types, register map, timing constants.
`default_nettype none
package ktlc_pkg;

  typedef struct packed {
    logic line1_current;
    logic line2_current;
    logic line1_a_lead;
    logic line2_a_lead;
    logic line1_ring_raw;
    logic line2_ring_raw;
  } in_word_t;

  typedef struct packed {
    logic line1_hold_relay;
    logic line2_hold_relay;
    logic line1_ring_relay;
    logic line2_ring_relay;
    logic line1_lamp;
    logic line2_lamp;
    logic ring_generator_power;
    logic status_led;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  ms_per_tick;
    logic [7:0]  hold_verify_ticks;
    logic [7:0]  ring_debounce_ticks;
    logic [15:0] ring_linger_ms;
  } cfg_t;

  typedef struct packed {
    logic wink;
    logic flash;
    logic led;
  } phase_t;

  typedef struct packed {
    logic hold;
    logic ring;
    logic lamp;
    logic linger_nz;
  } line_out_t;

  typedef enum logic [1:0] {
    REG_MS_PER_TICK  = 2'd0,
    REG_HOLD_VERIFY  = 2'd1,
    REG_RING_DEBOUNCE = 2'd2,
    REG_RING_LINGER  = 2'd3
  } reg_idx_t;

  localparam logic [9:0]  MS_PER_TICK_RST  = 10'd8;
  localparam logic [7:0]  HOLD_VERIFY_RST  = 8'd6;
  localparam logic [7:0]  RING_DEBOUNCE_RST = 8'd62;
  localparam logic [15:0] RING_LINGER_RST  = 16'd6000;

  localparam logic [10:0] PHASE_WRAP   = 11'd1000;
  localparam logic [10:0] PHASE_WRAP2  = 11'd2000;
  localparam logic [9:0]  WINK_ON_A    = 10'd100;
  localparam logic [9:0]  HALF_SEC     = 10'd500;
  localparam logic [9:0]  WINK_ON_B    = 10'd600;

endpackage
`default_nettype wire

// ===== design/ktlc_cfg.sv =====
// APB-style configuration register file.
`default_nettype none
module ktlc_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ktlc_pkg::cfg_t   cfg
);
  import ktlc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ms_per_tick         <= MS_PER_TICK_RST;
      cfg_r.hold_verify_ticks   <= HOLD_VERIFY_RST;
      cfg_r.ring_debounce_ticks <= RING_DEBOUNCE_RST;
      cfg_r.ring_linger_ms      <= RING_LINGER_RST;
    end else if (wr) begin
      unique case (idx)
        REG_MS_PER_TICK:   cfg_r.ms_per_tick         <= pwdata[9:0];
        REG_HOLD_VERIFY:   cfg_r.hold_verify_ticks   <= pwdata[7:0];
        REG_RING_DEBOUNCE: cfg_r.ring_debounce_ticks <= pwdata[7:0];
        REG_RING_LINGER:   cfg_r.ring_linger_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MS_PER_TICK:   prdata = {22'd0, cfg_r.ms_per_tick};
      REG_HOLD_VERIFY:   prdata = {24'd0, cfg_r.hold_verify_ticks};
      REG_RING_DEBOUNCE: prdata = {24'd0, cfg_r.ring_debounce_ticks};
      REG_RING_LINGER:   prdata = {16'd0, cfg_r.ring_linger_ms};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ktlc_phase.sv =====
// Millisecond phase counter with hold wink, ring flash and heartbeat decode.
`default_nettype none
module ktlc_phase (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [9:0] ms_per_tick,
  output ktlc_pkg::phase_t ph
);
  import ktlc_pkg::*;

  logic [9:0]  phase_r, phase_nxt;
  logic [10:0] sum;

  assign sum = {1'b0, phase_r} + {1'b0, ms_per_tick};

  always_comb begin
    priority if (sum >= PHASE_WRAP2) phase_nxt = 10'(sum - PHASE_WRAP2);
    else if (sum >= PHASE_WRAP)      phase_nxt = 10'(sum - PHASE_WRAP);
    else                             phase_nxt = sum[9:0];
  end

  // phase_nxt stays below 1000, so the upper wink window has no top check
  assign ph.led   = phase_nxt >= HALF_SEC;
  assign ph.flash = phase_nxt >= HALF_SEC;
  assign ph.wink  = (phase_nxt >= WINK_ON_A && phase_nxt <= HALF_SEC) ||
                    (phase_nxt >= WINK_ON_B);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ktlc_line.sv =====
// One line: ring debounce, ring linger, hold verify and line state.
`default_nettype none
module ktlc_line (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         cur,
  input  wire logic         alead,
  input  wire logic         raw,
  input  wire ktlc_pkg::cfg_t    cfg,
  input  wire ktlc_pkg::phase_t  ph,
  output ktlc_pkg::line_out_t lo
);
  import ktlc_pkg::*;

  logic        held_r, held_nxt;
  logic [7:0]  verify_r, verify_nxt;
  logic [7:0]  db_r, db_nxt;
  logic [15:0] linger_r, linger_nxt;
  logic [15:0] linger_dec, linger_load;
  logic [15:0] ms_ext;
  logic [7:0]  verify_dec;
  logic        ringing;

  assign ms_ext     = {6'd0, cfg.ms_per_tick};
  assign db_nxt     = raw ? cfg.ring_debounce_ticks : ((db_r != 8'd0) ? db_r - 8'd1 : 8'd0);
  assign ringing    = db_nxt != 8'd0;
  assign linger_dec = (linger_r > ms_ext) ? linger_r - ms_ext : 16'd0;
  assign linger_load = ringing ? cfg.ring_linger_ms : linger_dec;
  assign verify_dec = verify_r - 8'd1;

  always_comb begin
    held_nxt   = 1'b0;
    verify_nxt = 8'd0;
    linger_nxt = 16'd0;
    lo.hold    = 1'b0;
    lo.ring    = 1'b0;
    lo.lamp    = 1'b0;
    if (cur) begin
      if (held_r) begin
        lo.hold = ~alead;
        lo.lamp = alead | ph.wink;
      end else if (alead) begin
        lo.lamp = 1'b1;
      end else if (verify_r == 8'd0) begin
        verify_nxt = cfg.hold_verify_ticks;
        lo.lamp    = 1'b1;
      end else begin
        verify_nxt = verify_dec;
        lo.hold    = verify_dec == 8'd0;
        lo.lamp    = (verify_dec != 8'd0) | ph.wink;
      end
    end else if (linger_load != 16'd0) begin
      linger_nxt = linger_load;
      lo.ring    = ringing;
      lo.lamp    = ph.flash;
    end
    held_nxt     = lo.hold;
    lo.linger_nz = linger_nxt != 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      verify_r <= '0;
      db_r     <= '0;
      linger_r <= '0;
    end else if (en) begin
      held_r   <= held_nxt;
      verify_r <= verify_nxt;
      db_r     <= db_nxt;
      linger_r <= linger_nxt;
    end
  end

  a_hold_ring_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(lo.hold && lo.ring)) else $error("hold and ring relay both driven");
  a_held_no_verify: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> verify_r == 8'd0) else $error("verify count running while held");
  a_cur_clears_linger: assert property (@(posedge clk) disable iff (!rst_n)
    en && cur |=> linger_r == 16'd0) else $error("linger left after line current");
  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    !cur && !lo.linger_nz |-> !lo.lamp && !lo.ring) else $error("idle line lit");

endmodule
`default_nettype wire

// ===== design/key_telephone_line_controller.sv =====
// Top level of the two-line key telephone line controller.
//
// channel | ports                                  | word
// input   | in_valid, in_stall, in_data            | one loop tick of sense bits
// output  | out_valid, out_stall, out_data         | relay, lamp and LED drives
// config  | psel, penable, pwrite, paddr, pwdata,  | four registers at 4*i
//         | prdata, pready                         |
//
// One tick per cycle while the output is not stalled: the result word is registered
// and valid in the cycle after acceptance. Line state, phase and timers all update in the accepting cycle.
// Synchronous active-low reset clears state and loads register defaults.
// A tick is taken while the output register is empty or being drained; a
// stalled result holds and blocks only further input.
`default_nettype none
module key_telephone_line_controller (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ktlc_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ktlc_pkg::out_word_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ktlc_pkg::*;

  cfg_t      cfg;
  phase_t    ph;
  line_out_t l1, l2;
  logic      acc;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  ktlc_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ktlc_phase u_phase (
    .clk, .rst_n, .en(acc), .ms_per_tick(cfg.ms_per_tick), .ph
  );

  ktlc_line u_line1 (
    .clk, .rst_n, .en(acc), .cur(in_data.line1_current), .alead(in_data.line1_a_lead),
    .raw(in_data.line1_ring_raw), .cfg, .ph, .lo(l1)
  );

  ktlc_line u_line2 (
    .clk, .rst_n, .en(acc), .cur(in_data.line2_current), .alead(in_data.line2_a_lead),
    .raw(in_data.line2_ring_raw), .cfg, .ph, .lo(l2)
  );

  always_comb begin
    out_data_nxt.line1_hold_relay     = l1.hold;
    out_data_nxt.line2_hold_relay     = l2.hold;
    out_data_nxt.line1_ring_relay     = l1.ring;
    out_data_nxt.line2_ring_relay     = l2.ring;
    out_data_nxt.line1_lamp           = l1.lamp;
    out_data_nxt.line2_lamp           = l2.lamp;
    out_data_nxt.ring_generator_power = l1.linger_nz | l2.linger_nz;
    out_data_nxt.status_led           = ph.led;
  end

  assign out_valid_nxt = acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r) else $error("input stalled with empty output register");
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r) else $error("accepted tick produced no word");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r) else $error("output valid after reset");

endmodule
`default_nettype wire
